### sv/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

    // Event kinds carried by the input beat
    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_TRIGGER = 2'd1;
    localparam logic [1:0] MODE_CAPTURE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PING_HOLDOFF = 2'd0;
    localparam logic [1:0] CFG_ECHO_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_MIN_DIST     = 2'd2;
    localparam logic [1:0] CFG_MAX_DIST     = 2'd3;

    // Reported phase codes
    localparam logic [1:0] PHASE_CODE_IDLE = 2'd0;
    localparam logic [1:0] PHASE_CODE_RISE = 2'd1;
    localparam logic [1:0] PHASE_CODE_FALL = 2'd2;

    localparam int TIME_W = 32;
    localparam int US_W   = 20;
    localparam int CAP_W  = 16;
    localparam int DIST_W = 13;
    localparam int CFG_DATA_W = 20;

    // Reset values of the configuration registers
    localparam logic [US_W-1:0]   PING_HOLDOFF_RST = 20'd60000;
    localparam logic [US_W-1:0]   ECHO_TIMEOUT_RST = 20'd30000;
    localparam logic [DIST_W-1:0] MIN_DIST_RST     = 13'd20;
    localparam logic [DIST_W-1:0] MAX_DIST_RST     = 13'd4000;

    // width*5/58 == floor(floor(width*5/2) / 29); 1/29 as ceil(2^23/29)
    localparam int               MM_SHIFT = 23;
    localparam logic [18:0]      MM_RECIP = 19'd289263;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_RISE = 3'b010,
        PH_FALL = 3'b100
    } phase_t;

    typedef struct packed {
        logic [US_W-1:0]   ping_holdoff_us;
        logic [US_W-1:0]   echo_timeout_us;
        logic [DIST_W-1:0] min_range_mm;
        logic [DIST_W-1:0] max_range_mm;
    } cfg_t;

    typedef struct packed {
        logic              trigger_accepted;
        logic              measurement_ready;
        logic              timed_out;
        logic [DIST_W-1:0] range_mm;
        logic [1:0]        phase;
    } result_t;

endpackage

### sv/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger: input, config and result registers.
//
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------------
//  s_ (in)  | s_valid / s_ready   | s_mode, s_now_us, s_capture_time
//  m_ (out) | m_valid / m_ready   | m_trigger_accepted, m_measurement_ready,
//           |                     | m_timed_out, m_range_mm, m_phase
//  cfg_     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One beat per cycle while m_ is not stalled; each beat passes through the input
// register and then the result register before it appears on m_.
// The sequencer state and the width-to-mm multiply sit between the two registers.
// aresetn is synchronous, active low; it clears the phase, flags, timestamps,
// valid bits and loads the configuration defaults.
// A stall on m_ holds the result register and then the input register; s_ready
// drops only when both are full.
module ultrasonic_echo_ranger_top (
    input  logic                       aclk,
    input  logic                       aresetn,

    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_mode,
    input  logic [uer_pkg::TIME_W-1:0] s_now_us,
    input  logic [uer_pkg::CAP_W-1:0]  s_capture_time,

    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_trigger_accepted,
    output logic                       m_measurement_ready,
    output logic                       m_timed_out,
    output logic [uer_pkg::DIST_W-1:0] m_range_mm,
    output logic [1:0]                 m_phase,

    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data
);
    import uer_pkg::*;

    // input register
    logic              in_vld_reg;
    logic [1:0]        in_mode_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [CAP_W-1:0]  in_cap_reg;

    // result register
    logic              out_vld_reg;
    result_t           res_reg;
    result_t           res_next;

    cfg_t              cfg_reg;

    logic              out_free;
    logic              fire;
    logic              s_take;

    // advance the result stage when it is empty or being drained
    assign out_free  = !out_vld_reg || m_ready;
    assign fire      = in_vld_reg && out_free;
    assign s_ready   = !in_vld_reg || out_free;
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    uer_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .fire         (fire),
        .mode         (in_mode_reg),
        .now_us       (in_now_reg),
        .capture_time (in_cap_reg),
        .cfg          (cfg_reg),
        .result       (res_next)
    );

    // input stage: hold the beat until the sequencer consumes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_mode_reg <= s_mode;
            in_now_reg  <= s_now_us;
            in_cap_reg  <= s_capture_time;
        end
    end

    // result stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_free) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res_next;
        end
    end

    // configuration writes; the user must issue them only while the block is idle (not enforced here)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ping_holdoff_us <= PING_HOLDOFF_RST;
            cfg_reg.echo_timeout_us <= ECHO_TIMEOUT_RST;
            cfg_reg.min_range_mm    <= MIN_DIST_RST;
            cfg_reg.max_range_mm    <= MAX_DIST_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PING_HOLDOFF: cfg_reg.ping_holdoff_us <= cfg_data[US_W-1:0];
                CFG_ECHO_TIMEOUT: cfg_reg.echo_timeout_us <= cfg_data[US_W-1:0];
                CFG_MIN_DIST:     cfg_reg.min_range_mm    <= cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:     cfg_reg.max_range_mm    <= cfg_data[DIST_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign m_valid             = out_vld_reg;
    assign m_trigger_accepted  = res_reg.trigger_accepted;
    assign m_measurement_ready = res_reg.measurement_ready;
    assign m_timed_out         = res_reg.timed_out;
    assign m_range_mm          = res_reg.range_mm;
    assign m_phase             = res_reg.phase;

endmodule

### sv/uer_mm_conv.sv
// Echo width to millimetres: width*5/58 by reciprocal multiply.
module uer_mm_conv (
    input  logic [uer_pkg::CAP_W-1:0]  width,
    output logic [uer_pkg::DIST_W-1:0] dist_mm
);
    import uer_pkg::*;

    logic [CAP_W+2:0]  prod5;
    logic [CAP_W+1:0]  half;
    logic [CAP_W+20:0] scaled;
    logic [CAP_W+20-MM_SHIFT:0] quot;

    always_comb begin
        prod5  = {3'b000, width} + {1'b0, width, 2'b00};
        half   = prod5[CAP_W+2:1];
        scaled = {19'd0, half} * {18'd0, MM_RECIP};
        quot   = scaled[CAP_W+20:MM_SHIFT];
        // largest quotient is 5649, so the low bits carry it all
        dist_mm = quot[DIST_W-1:0];
    end

endmodule

### sv/uer_seq.sv
// Ranging sequencer: phase, ready flag, timestamps and result formation.
module uer_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       fire,
    input  logic [1:0]                 mode,
    input  logic [uer_pkg::TIME_W-1:0] now_us,
    input  logic [uer_pkg::CAP_W-1:0]  capture_time,
    input  uer_pkg::cfg_t              cfg,
    output uer_pkg::result_t           result
);
    import uer_pkg::*;

    phase_t            phase_reg,  phase_next;
    logic              ready_reg,  ready_next;
    logic [CAP_W-1:0]  rise_reg,   rise_next;
    logic [DIST_W-1:0] dist_reg,   dist_next;
    logic [TIME_W-1:0] start_reg,  start_next;
    logic [TIME_W-1:0] ping_reg,   ping_next;

    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_ping;
    logic [CAP_W-1:0]  echo_width;
    logic [DIST_W-1:0] echo_mm;
    logic              accepted;
    logic              tmo;

    uer_mm_conv u_mm_conv (
        .width   (echo_width),
        .dist_mm (echo_mm)
    );

    always_comb begin
        since_start = now_us - start_reg;
        since_ping  = now_us - ping_reg;
        echo_width  = capture_time - rise_reg;

        phase_next = phase_reg;
        ready_next = ready_reg;
        rise_next  = rise_reg;
        dist_next  = dist_reg;
        start_next = start_reg;
        ping_next  = ping_reg;
        accepted   = 1'b0;
        tmo        = 1'b0;

        case (mode)
            MODE_TICK: begin
                if (phase_reg != PH_IDLE &&
                    since_start > {{(TIME_W-US_W){1'b0}}, cfg.echo_timeout_us}) begin
                    phase_next = PH_IDLE;
                    ready_next = 1'b1;
                    dist_next  = '0;
                    tmo        = 1'b1;
                end
            end
            MODE_TRIGGER: begin
                if (phase_reg == PH_IDLE &&
                    since_ping >= {{(TIME_W-US_W){1'b0}}, cfg.ping_holdoff_us}) begin
                    ready_next = 1'b0;
                    phase_next = PH_RISE;
                    start_next = now_us;
                    ping_next  = now_us;
                    accepted   = 1'b1;
                end
            end
            MODE_CAPTURE: begin
                if (phase_reg == PH_RISE) begin
                    rise_next  = capture_time;
                    phase_next = PH_FALL;
                end else if (phase_reg == PH_FALL) begin
                    dist_next  = echo_mm;
                    ready_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        result.trigger_accepted  = accepted;
        result.measurement_ready = ready_next;
        result.timed_out         = tmo;
        // when min exceeds max, values above max clamp to max and all others to min
        if (dist_next > cfg.max_range_mm) begin
            result.range_mm = cfg.max_range_mm;
        end else if (dist_next < cfg.min_range_mm) begin
            result.range_mm = cfg.min_range_mm;
        end else begin
            result.range_mm = dist_next;
        end
        case (phase_next)
            PH_IDLE: result.phase = PHASE_CODE_IDLE;
            PH_RISE: result.phase = PHASE_CODE_RISE;
            PH_FALL: result.phase = PHASE_CODE_FALL;
            default: result.phase = PHASE_CODE_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            ready_reg <= 1'b0;
            rise_reg  <= '0;
            dist_reg  <= '0;
            start_reg <= '0;
            ping_reg  <= '0;
        end else if (fire) begin
            phase_reg <= phase_next;
            ready_reg <= ready_next;
            rise_reg  <= rise_next;
            dist_reg  <= dist_next;
            start_reg <= start_next;
            ping_reg  <= ping_next;
        end
    end

endmodule
